/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset.
`define JRF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define JRF_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`else

`define JRF_ASSERT(lbl, clk, rstn, prop, msg)
`define JRF_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

/* rtl/jrf_pkg.sv */
// Types and constants of the RTP/JPEG fragmenter.
`timescale 1ns / 1ps

package jrf_pkg;

  localparam logic [15:0] MPS_RESET      = 16'd1400;
  localparam int unsigned MAIN_HDR_BYTES = 8;
  localparam int unsigned QT_HDR_BYTES   = 4;

  // Byte positions of a command's expansion in the back end
  localparam logic [3:0] STEP_MH_FIRST = 4'd0;
  localparam logic [3:0] STEP_OFF_HI   = 4'd1;
  localparam logic [3:0] STEP_OFF_MID  = 4'd2;
  localparam logic [3:0] STEP_OFF_LO   = 4'd3;
  localparam logic [3:0] STEP_TYPE     = 4'd4;
  localparam logic [3:0] STEP_Q        = 4'd5;
  localparam logic [3:0] STEP_WIDTH    = 4'd6;
  localparam logic [3:0] STEP_MH_LAST  = 4'd7;
  localparam logic [3:0] STEP_QT_MBZ   = 4'd8;
  localparam logic [3:0] STEP_QT_PREC  = 4'd9;
  localparam logic [3:0] STEP_QT_LEN_H = 4'd10;
  localparam logic [3:0] STEP_QT_LAST  = 4'd11;
  localparam logic [3:0] STEP_DATA     = 4'd12;

  typedef enum logic [1:0] {
    OP_FRAME = 2'd0,
    OP_TABLE = 2'd1,
    OP_SCAN  = 2'd2
  } jrf_op_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_TABLES = 3'b010,
    PH_SCAN   = 3'b100
  } jrf_phase_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] timestamp;
    logic [7:0]  type_specific;
    logic [7:0]  jpeg_type;
    logic [7:0]  q_factor;
    logic [7:0]  width_units;
    logic [7:0]  height_units;
    logic [7:0]  qt0_len;
    logic [7:0]  qt1_len;
    logic [23:0] scan_len;
    logic [7:0]  data_byte;
  } jrf_in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        pkt_first;
    logic        pkt_end;
    logic        marker;
    logic [31:0] pkt_timestamp;
    logic        error;
    logic        run_last;
  } jrf_out_t;

  // One classified item, as queued between front and back
  typedef struct packed {
    logic        err;
    logic        has_hdr;
    logic        hdr_end;
    logic        has_qth;
    logic        has_data;
    logic        data_end;
    logic        mark;
    logic [23:0] offset;
    logic [39:0] hdr_fields;
    logic [31:0] ts;
    logic [8:0]  qsum;
    logic [7:0]  data;
  } jrf_cmd_t;

endpackage

/* rtl/jrf_front.sv */
// Front end: frame state, budgets and classification of each input item.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jrf_front import jrf_pkg::*; #(
  parameter int unsigned QT_TABLE_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        take_i,
  input  jrf_in_t     item_i,
  output jrf_cmd_t    cmd_o
);

  localparam int unsigned QT_W = $clog2(2 * QT_TABLE_BYTES + 1);
  localparam logic [8:0]  QT_MAX = 9'(2 * QT_TABLE_BYTES);

  logic [15:0]   mps_q;
  jrf_phase_e    phase_q, phase_d;
  logic [23:0]   offset_q, offset_d;
  logic [23:0]   left_q, left_d;     // scan bytes still to come
  logic [23:0]   rem_q, rem_d;       // scan bytes from start of open packet
  logic [15:0]   fill_q, fill_d;
  logic [QT_W-1:0] qt_left_q, qt_left_d;
  logic [39:0]   hdr_q, hdr_d;
  logic [31:0]   ts_q, ts_d;
  logic          scan_zero_q, scan_zero_d;
  logic          first_q, first_d;
  logic          mark_first_q, mark_first_d;
  logic [15:0]   fbud_q, fbud_d;
  logic [15:0]   cbud_q, cbud_d;

  logic [8:0]    qsum;
  logic [9:0]    hdr_len;
  logic [15:0]   fbud_new;
  logic [15:0]   budget;
  logic          scan_end;

  assign qsum     = {1'b0, item_i.qt0_len} + {1'b0, item_i.qt1_len};
  assign hdr_len  = (qsum != 9'd0) ? ({1'b0, qsum} + 10'(MAIN_HDR_BYTES + QT_HDR_BYTES))
                                   : 10'(MAIN_HDR_BYTES);
  assign fbud_new = mps_q - {6'd0, hdr_len};
  assign budget   = first_q ? fbud_q : cbud_q;
  assign scan_end = (({1'b0, fill_q} + 17'd1) >= {1'b0, budget}) || (left_q == 24'd1);

  always_comb begin
    phase_d      = phase_q;
    offset_d     = offset_q;
    left_d       = left_q;
    rem_d        = rem_q;
    fill_d       = fill_q;
    qt_left_d    = qt_left_q;
    hdr_d        = hdr_q;
    ts_d         = ts_q;
    scan_zero_d  = scan_zero_q;
    first_d      = first_q;
    mark_first_d = mark_first_q;
    fbud_d       = fbud_q;
    cbud_d       = cbud_q;

    cmd_o            = '0;
    cmd_o.hdr_fields = hdr_q;
    cmd_o.ts         = ts_q;
    cmd_o.offset     = offset_q;
    cmd_o.data       = item_i.data_byte;

    unique case (item_i.op)
      OP_FRAME: begin
        if (qsum > QT_MAX || mps_q <= {6'd0, hdr_len}) begin
          cmd_o   = '0;
          cmd_o.err = 1'b1;
          phase_d = PH_IDLE;
        end else begin
          ts_d  = item_i.timestamp;
          hdr_d = {item_i.type_specific, item_i.jpeg_type, item_i.q_factor,
                   item_i.width_units, item_i.height_units};
          fbud_d       = fbud_new;
          cbud_d       = mps_q - 16'(MAIN_HDR_BYTES);
          offset_d     = '0;
          left_d       = item_i.scan_len;
          rem_d        = item_i.scan_len;
          fill_d       = '0;
          first_d      = 1'b1;
          qt_left_d    = qsum[QT_W-1:0];
          scan_zero_d  = (item_i.scan_len == 24'd0);
          mark_first_d = (item_i.scan_len <= {8'd0, fbud_new});
          cmd_o.hdr_fields = hdr_d;
          cmd_o.ts         = item_i.timestamp;
          cmd_o.offset     = '0;
          cmd_o.has_hdr    = 1'b1;
          cmd_o.hdr_end    = (qsum == 9'd0) && scan_zero_d;
          cmd_o.has_qth    = (qsum != 9'd0);
          cmd_o.qsum       = qsum;
          cmd_o.mark       = mark_first_d;
          if (qsum != 9'd0) begin
            phase_d = PH_TABLES;
          end else begin
            phase_d = scan_zero_d ? PH_IDLE : PH_SCAN;
          end
        end
      end
      OP_TABLE: begin
        if (phase_q == PH_TABLES && qt_left_q != '0) begin
          qt_left_d      = qt_left_q - QT_W'(1);
          cmd_o.has_data = 1'b1;
          cmd_o.data_end = (qt_left_d == '0) && scan_zero_q;
          cmd_o.mark     = mark_first_q;
          if (qt_left_d == '0) begin
            phase_d = scan_zero_q ? PH_IDLE : PH_SCAN;
          end
        end else begin
          cmd_o     = '0;
          cmd_o.err = 1'b1;
        end
      end
      OP_SCAN: begin
        if (phase_q == PH_SCAN && left_q != 24'd0) begin
          cmd_o.has_hdr  = !first_q && (fill_q == 16'd0);
          cmd_o.has_data = 1'b1;
          cmd_o.data_end = scan_end;
          cmd_o.mark     = (rem_q <= {8'd0, budget});
          offset_d       = offset_q + 24'd1;
          left_d         = left_q - 24'd1;
          fill_d         = fill_q + 16'd1;
          if (scan_end) begin
            fill_d  = '0;
            first_d = 1'b0;
            rem_d   = left_d;
          end
          if (left_d == 24'd0) begin
            phase_d = PH_IDLE;
          end
        end else begin
          cmd_o     = '0;
          cmd_o.err = 1'b1;
        end
      end
      default: begin
        cmd_o     = '0;
        cmd_o.err = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mps_q        <= MPS_RESET;
      phase_q      <= PH_IDLE;
      offset_q     <= '0;
      left_q       <= '0;
      rem_q        <= '0;
      fill_q       <= '0;
      qt_left_q    <= '0;
      hdr_q        <= '0;
      ts_q         <= '0;
      scan_zero_q  <= 1'b1;
      first_q      <= 1'b1;
      mark_first_q <= 1'b0;
      fbud_q       <= '0;
      cbud_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        mps_q <= cfg_wdata_i;
      end
      if (take_i) begin
        phase_q      <= phase_d;
        offset_q     <= offset_d;
        left_q       <= left_d;
        rem_q        <= rem_d;
        fill_q       <= fill_d;
        qt_left_q    <= qt_left_d;
        hdr_q        <= hdr_d;
        ts_q         <= ts_d;
        scan_zero_q  <= scan_zero_d;
        first_q      <= first_d;
        mark_first_q <= mark_first_d;
        fbud_q       <= fbud_d;
        cbud_q       <= cbud_d;
      end
    end
  end

  `JRF_ASSERT(a_tables_have_bytes, clk_i, rst_ni, (phase_q != PH_TABLES) || (qt_left_q != '0), "table phase with no table bytes left")
  `JRF_ASSERT(a_scan_has_bytes, clk_i, rst_ni, (phase_q != PH_SCAN) || (left_q != 24'd0), "scan phase with no scan bytes left")

endmodule

/* rtl/jrf_queue.sv */
// Two-entry command queue between front and back end.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jrf_queue import jrf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  jrf_cmd_t push_cmd_i,
  input  logic     pop_i,
  output logic     full_o,
  output logic     head_valid_o,
  output jrf_cmd_t head_o
);

  jrf_cmd_t   slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o       = (cnt_q == 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  `JRF_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o, "push into full queue")
  `JRF_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && !head_valid_o, "pop from empty queue")

endmodule

/* rtl/jrf_back.sv */
// Back end: expands one queued command into payload bytes, one per cycle unless stalled.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jrf_back import jrf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     head_valid_i,
  input  jrf_cmd_t head_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output jrf_out_t out_item_o
);

  logic       started_q;
  logic [3:0] step_q;
  logic       out_valid_q;
  jrf_out_t   out_q;

  logic [3:0] cur, nxt;
  logic       last, advance;
  jrf_out_t   res;

  always_comb begin
    if (started_q) begin
      cur = step_q;
    end else if (head_i.has_hdr) begin
      cur = STEP_MH_FIRST;
    end else begin
      cur = STEP_DATA;
    end

    if (cur == STEP_MH_LAST) begin
      nxt = head_i.has_qth ? STEP_QT_MBZ : STEP_DATA;
    end else begin
      nxt = cur + 4'd1;
    end

    last = head_i.err || (cur == STEP_DATA) || (cur == STEP_QT_LAST) ||
           ((cur == STEP_MH_LAST) && !head_i.has_qth && !head_i.has_data);

    res               = '0;
    res.pkt_first     = (cur == STEP_MH_FIRST);
    res.pkt_end       = ((cur == STEP_MH_LAST) && head_i.hdr_end) ||
                        ((cur == STEP_DATA) && head_i.data_end);
    res.marker        = head_i.mark;
    res.pkt_timestamp = head_i.ts;
    res.run_last      = last;
    case (cur)
      STEP_MH_FIRST: res.out_byte = head_i.hdr_fields[39:32];
      STEP_OFF_HI:   res.out_byte = head_i.offset[23:16];
      STEP_OFF_MID:  res.out_byte = head_i.offset[15:8];
      STEP_OFF_LO:   res.out_byte = head_i.offset[7:0];
      STEP_TYPE:     res.out_byte = head_i.hdr_fields[31:24];
      STEP_Q:        res.out_byte = head_i.hdr_fields[23:16];
      STEP_WIDTH:    res.out_byte = head_i.hdr_fields[15:8];
      STEP_MH_LAST:  res.out_byte = head_i.hdr_fields[7:0];
      STEP_QT_LEN_H: res.out_byte = {7'd0, head_i.qsum[8]};
      STEP_QT_LAST:  res.out_byte = head_i.qsum[7:0];
      STEP_DATA:     res.out_byte = head_i.data;
      default:       res.out_byte = 8'd0;
    endcase

    if (head_i.err) begin
      res          = '0;
      res.error    = 1'b1;
      res.run_last = 1'b1;
    end
  end

  assign advance     = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o       = advance && last;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      step_q      <= STEP_MH_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        started_q   <= !last;
        step_q      <= nxt;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  `JRF_ASSERT(a_err_is_single, clk_i, rst_ni, !(out_valid_q && out_q.error) || (out_q.run_last && !out_q.pkt_first), "error result not a lone result")
  `JRF_NEVER(a_pop_only_at_end, clk_i, rst_ni, pop_o && started_q && (step_q == STEP_MH_FIRST), "command popped mid-header")

endmodule

/* rtl/jpeg_rtp_fragmenter_unit.sv */
// Top level of the RTP/JPEG payload fragmenter (RFC 2435 style).
`timescale 1ns / 1ps
//
//  channel   direction  handshake               payload
//  --------  ---------  ----------------------  ------------------------------
//  in        input      in_valid_i / in_stall_o   in_item_i  (jrf_in_t)
//  out       output     out_valid_o / out_stall_i out_item_o (jrf_out_t)
//  cfg       input      cfg_we_i                  cfg_wdata_i (max packet size)
//
//  Every result leaves at one byte per cycle, unless out_stall_i holds it,
//  from the back end's output register; an item yields one result per byte
//  (12 for a frame start with tables, 9 for a scan byte opening a packet).
//  Input items are taken every cycle while the two-entry queue has room, so
//  a scan stream runs at one byte per cycle except at packet headers or stalls.
//  Reset (rst_ni low, asynchronous) empties the queue and output register,
//  puts the frame state in idle and the packet size at 1400.
//  in_stall_o is the queue's full flag; out_stall_i only holds the back end.
//
module jpeg_rtp_fragmenter_unit import jrf_pkg::*; #(
  parameter int unsigned QT_TABLE_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  jrf_in_t     in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output jrf_out_t    out_item_o
);

  logic     take;
  logic     q_full;
  logic     head_valid;
  logic     pop;
  jrf_cmd_t cmd;
  jrf_cmd_t head;

  // An item is taken when the queue can hold its command
  assign in_stall_o = q_full;
  assign take       = in_valid_i && !q_full;

  // Front: classifies the item, keeps frame and packet state
  jrf_front #(
    .QT_TABLE_BYTES(QT_TABLE_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .take_i      (take),
    .item_i      (in_item_i),
    .cmd_o       (cmd)
  );

  // Queue: decouples classification from byte emission
  jrf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (take),
    .push_cmd_i   (cmd),
    .pop_i        (pop),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // Back: turns each command into header, table header and data bytes
  jrf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule
